// ===== rtl/cps_pkg.sv =====
// Shared types, codes and constants of the contactor precharge sequencer.
package cps_pkg;

    localparam int unsigned MS_COUNTER_BITS = 17;
    localparam int unsigned CURRENT_BITS    = 22;
    localparam int unsigned CFG_DATA_BITS   = 16;
    localparam int unsigned CFG_INDEX_BITS  = 2;

    localparam logic [MS_COUNTER_BITS-1:0] MS_MAX        = '1;
    localparam logic [MS_COUNTER_BITS-1:0] RELAY_DROP_MS = MS_COUNTER_BITS'(500);
    localparam logic [MS_COUNTER_BITS-1:0] FAULT_HOLD_MS = MS_COUNTER_BITS'(60000);

    localparam logic signed [CURRENT_BITS-1:0] SETTLED_HI_MA = 22'sd500;
    localparam logic signed [CURRENT_BITS-1:0] SETTLED_LO_MA = -22'sd500;

    localparam logic [CFG_DATA_BITS-1:0] TIMEOUT_RESET_MS = 16'd5000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_OPEN  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PRECHARGE_ENABLE  = 2'd0,
        CFG_SENSOR_PRESENT    = 2'd1,
        CFG_PRECHARGE_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MODE_OPEN        = 4'b0001,
        MODE_PRECHARGING = 4'b0010,
        MODE_CONNECTED   = 4'b0100,
        MODE_FAULT       = 4'b1000
    } t_mode;

    localparam logic [1:0] MODE_CODE_OPEN        = 2'd0;
    localparam logic [1:0] MODE_CODE_PRECHARGING = 2'd1;
    localparam logic [1:0] MODE_CODE_CONNECTED   = 2'd2;
    localparam logic [1:0] MODE_CODE_FAULT       = 2'd3;

    typedef struct packed {
        logic                     precharge_enable;
        logic                     sensor_present;
        logic [CFG_DATA_BITS-1:0] precharge_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                     cmd;
        logic signed [CURRENT_BITS-1:0] pack_current_ma;
    } t_item;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_OPEN:        c = MODE_CODE_OPEN;
            MODE_PRECHARGING: c = MODE_CODE_PRECHARGING;
            MODE_CONNECTED:   c = MODE_CODE_CONNECTED;
            MODE_FAULT:       c = MODE_CODE_FAULT;
            default:          c = MODE_CODE_OPEN;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cps_channels.sv =====
// Valid/ready channel interfaces: command items, results and register writes.
interface cps_item_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             cmd;
    logic signed [cps_pkg::CURRENT_BITS-1:0] pack_current_ma;

    modport source (output valid, output cmd, output pack_current_ma, input ready);
    modport sink   (input valid, input cmd, input pack_current_ma, output ready);
endinterface

interface cps_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       precharge_relay;
    logic       main_relay;

    modport source (output valid, output mode, output precharge_relay, output main_relay,
                    input ready);
    modport sink   (input valid, input mode, input precharge_relay, input main_relay,
                    output ready);
endinterface

interface cps_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [cps_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [cps_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cps_cfg_regs.sv =====
// Configuration register file of the contactor precharge sequencer.
module cps_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cps_cfg_if.sink       s_cfg,
    output cps_pkg::t_cfg o_cfg
);

    cps_pkg::t_cfg r_cfg;
    cps_pkg::t_cfg n_cfg;

    assign s_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (s_cfg.valid) begin
            case (s_cfg.index)
                cps_pkg::CFG_PRECHARGE_ENABLE:  n_cfg.precharge_enable = s_cfg.data[0];
                cps_pkg::CFG_SENSOR_PRESENT:    n_cfg.sensor_present = s_cfg.data[0];
                cps_pkg::CFG_PRECHARGE_TIMEOUT: n_cfg.precharge_timeout_ms = s_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.precharge_enable     <= 1'b1;
            r_cfg.sensor_present       <= 1'b0;
            r_cfg.precharge_timeout_ms <= cps_pkg::TIMEOUT_RESET_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/cps_in_stage.sv =====
// Input register stage: holds one command beat until the sequencer takes it.
module cps_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cps_item_if.sink       s_in,
    input  logic           i_take,
    output logic           o_valid,
    output cps_pkg::t_item o_item
);

    logic           r_valid;
    cps_pkg::t_item r_item;
    logic           accept;

    assign s_in.ready = !r_valid || i_take;
    assign accept     = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd             <= s_in.cmd;
            r_item.pack_current_ma <= s_in.pack_current_ma;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/cps_fsm.sv =====
// Sequencer state, millisecond counter and the result register.
module cps_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cps_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  cps_pkg::t_item i_item,
    output logic           o_take,
    cps_result_if.source   m_out
);

    cps_pkg::t_mode                         r_mode, n_mode;
    logic [cps_pkg::MS_COUNTER_BITS-1:0]    r_ms, n_ms;
    logic                                   r_pre, n_pre;
    logic                                   r_main, n_main;
    logic                                   r_out_valid;

    logic [cps_pkg::MS_COUNTER_BITS-1:0]    ms_inc;
    logic                                   timed_out;
    logic                                   settled;

    assign o_take = i_valid && (!r_out_valid || m_out.ready);

    // tick advances the count first; all checks use the advanced value
    assign ms_inc    = (r_ms == cps_pkg::MS_MAX) ? r_ms : r_ms + 1'b1;
    assign timed_out = ms_inc >= cps_pkg::MS_COUNTER_BITS'(i_cfg.precharge_timeout_ms);
    assign settled   = (i_item.pack_current_ma > cps_pkg::SETTLED_LO_MA) &&
                       (i_item.pack_current_ma < cps_pkg::SETTLED_HI_MA);

    always_comb begin
        n_mode = r_mode;
        n_ms   = r_ms;
        n_pre  = r_pre;
        n_main = r_main;
        case (i_item.cmd)
            cps_pkg::CMD_TICK: begin
                n_ms = ms_inc;
                case (r_mode)
                    cps_pkg::MODE_PRECHARGING: begin
                        if (timed_out) begin
                            n_ms = '0;
                            if (i_cfg.sensor_present && !settled) begin
                                n_pre  = 1'b0;
                                n_main = 1'b0;
                                n_mode = cps_pkg::MODE_FAULT;
                            end else begin
                                n_main = 1'b1;
                                n_mode = cps_pkg::MODE_CONNECTED;
                            end
                        end
                    end
                    cps_pkg::MODE_CONNECTED: begin
                        if (ms_inc > cps_pkg::RELAY_DROP_MS) begin
                            n_pre = 1'b0;
                        end
                    end
                    cps_pkg::MODE_FAULT: begin
                        if (ms_inc >= cps_pkg::FAULT_HOLD_MS) begin
                            n_mode = cps_pkg::MODE_OPEN;
                        end
                    end
                    default: ;
                endcase
            end
            cps_pkg::CMD_CLOSE: begin
                if (r_mode != cps_pkg::MODE_CONNECTED && r_mode != cps_pkg::MODE_FAULT) begin
                    n_ms = '0;
                    if (i_cfg.precharge_enable) begin
                        n_pre  = 1'b1;
                        n_mode = cps_pkg::MODE_PRECHARGING;
                    end else begin
                        n_main = 1'b1;
                        n_mode = cps_pkg::MODE_CONNECTED;
                    end
                end
            end
            cps_pkg::CMD_OPEN: begin
                n_pre  = 1'b0;
                n_main = 1'b0;
                n_mode = cps_pkg::MODE_OPEN;
            end
            default: ;
        endcase
    end

    // state only moves with a taken beat, so it doubles as the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cps_pkg::MODE_OPEN;
            r_ms        <= '0;
            r_pre       <= 1'b0;
            r_main      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode <= n_mode;
                r_ms   <= n_ms;
                r_pre  <= n_pre;
                r_main <= n_main;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_out.valid           = r_out_valid;
    assign m_out.mode            = cps_pkg::mode_code(r_mode);
    assign m_out.precharge_relay = r_pre;
    assign m_out.main_relay      = r_main;

    a_open_relays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cps_pkg::MODE_OPEN || r_mode == cps_pkg::MODE_FAULT) |-> (!r_pre && !r_main))
        else $error("relay energized while open or faulted");

    a_precharge_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cps_pkg::MODE_PRECHARGING) |-> (r_pre && !r_main))
        else $error("bad relay drive while precharging");

    a_connected_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cps_pkg::MODE_CONNECTED) |-> r_main)
        else $error("main relay off while connected");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> ($stable(r_mode) && $stable(r_ms) && $stable(r_pre) && $stable(r_main)))
        else $error("state moved without a taken beat");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_out.ready) |-> !o_take)
        else $error("beat taken over an unread result");

endmodule

// ===== rtl/contactor_precharge_sequencer_core.sv =====
// Contactor precharge sequencer top level: register file, input stage and sequencer.
// Takes one command beat per clock while results are read (tick carrying pack current in mA,
// close or open) and returns one result beat per command giving the mode code and both relay
// drives after it. Each beat passes an input register and then the result register;
// a stall on the result channel backs up through the single input register. Registers
// (precharge enable, sensor present, precharge timeout in ms) are written through the
// configuration channel, which is always ready, and are meant to change only while idle.
module contactor_precharge_sequencer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cps_cfg_if.sink      i_cfg,
    cps_item_if.sink     i_item,
    cps_result_if.source o_result
);

    cps_pkg::t_cfg  cfg;
    cps_pkg::t_item item;
    logic           item_valid;
    logic           take;

    cps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cps_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (i_item),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    cps_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (item_valid),
        .i_item  (item),
        .o_take  (take),
        .m_out   (o_result)
    );

endmodule
